[rtl/ise_pkg.sv]
// shared widths, codes and defaults of the induced subgraph extractor
package ise_pkg;

    localparam int DEF_MAX_VERTICES = 1024;
    localparam int DEF_MAX_EDGES    = 8192;
    localparam int DEF_MAX_DEGREE   = 63;
    localparam int DEF_MAX_SELECTED = 1024;

    localparam int MODE_W    = 3;
    localparam int SLOT_W    = 13;
    localparam int VERTEX_W  = 10;
    localparam int PTR_W     = 14;
    localparam int EID_W     = 32;
    localparam int KIND_W    = 2;
    localparam int COL_W     = 10;
    localparam int TOTAL_W   = 14;
    localparam int STATUS_W  = 3;
    localparam int DEG_W     = 6;
    localparam int GVC_W     = 11;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 64;

    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [GVC_W-1:0]   GVC_RESET = 11'd1024;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_VERTEX_COUNT = 1'b0,
        CFG_EMIT_IDS     = 1'b1
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD_PTR  = 3'd0,
        MODE_LOAD_EDGE = 3'd1,
        MODE_APPEND    = 3'd2,
        MODE_EXTRACT   = 3'd3,
        MODE_NEW_SET   = 3'd4
    } mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_ACK     = 2'd0,
        KIND_EDGE    = 2'd1,
        KIND_ROW_END = 2'd2,
        KIND_ERROR   = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 3'd0,
        STAT_VERT_RANGE = 3'd1,
        STAT_UNSORTED   = 3'd2,
        STAT_LIST_FULL  = 3'd3,
        STAT_ROW_LONG   = 3'd4,
        STAT_BAD_POS    = 3'd5
    } status_t;

endpackage

[rtl/ise_graph_mem.sv]
// row pointer and edge slot memories of the loaded graph
module ise_graph_mem #(
    parameter int RAW = 11,
    parameter int EAW = 13,
    parameter int RP_DEPTH = 1025,
    parameter int ED_DEPTH = 8192
) (
    input  logic                         aclk,
    input  logic                         rp_we,
    input  logic [RAW-1:0]               rp_waddr,
    input  logic [ise_pkg::PTR_W-1:0]    rp_wdata,
    input  logic [RAW-1:0]               rp_raddr_a,
    input  logic [RAW-1:0]               rp_raddr_b,
    output logic [ise_pkg::PTR_W-1:0]    rp_rdata_a,
    output logic [ise_pkg::PTR_W-1:0]    rp_rdata_b,
    input  logic                         ed_we,
    input  logic [EAW-1:0]               ed_waddr,
    input  logic [ise_pkg::VERTEX_W-1:0] ed_wcol,
    input  logic [ise_pkg::EID_W-1:0]    ed_wid,
    input  logic [EAW-1:0]               ed_raddr,
    output logic [ise_pkg::VERTEX_W-1:0] ed_rcol,
    output logic [ise_pkg::EID_W-1:0]    ed_rid
);
    import ise_pkg::*;

    logic [PTR_W-1:0]          rp_mem [RP_DEPTH];
    logic [EID_W+VERTEX_W-1:0] ed_mem [ED_DEPTH];
    logic [EID_W+VERTEX_W-1:0] ed_word;

    always_ff @(posedge aclk) begin
        if (rp_we) begin
            rp_mem[rp_waddr] <= rp_wdata;
        end
        rp_rdata_a <= rp_mem[rp_raddr_a];
        rp_rdata_b <= rp_mem[rp_raddr_b];
    end

    always_ff @(posedge aclk) begin
        if (ed_we) begin
            ed_mem[ed_waddr] <= {ed_wid, ed_wcol};
        end
        ed_word <= ed_mem[ed_raddr];
    end

    assign ed_rcol = ed_word[VERTEX_W-1:0];
    assign ed_rid  = ed_word[EID_W+VERTEX_W-1:VERTEX_W];

endmodule

[rtl/ise_set_mem.sv]
// selected list and old-to-new vertex map memories
module ise_set_mem #(
    parameter int VAW = 10,
    parameter int SAW = 10,
    parameter int LIST_DEPTH = 1024,
    parameter int MAP_DEPTH = 1024
) (
    input  logic           aclk,
    input  logic           list_we,
    input  logic [SAW-1:0] list_waddr,
    input  logic [VAW-1:0] list_wdata,
    input  logic [SAW-1:0] list_raddr,
    output logic [VAW-1:0] list_rdata,
    input  logic           map_we,
    input  logic [VAW-1:0] map_waddr,
    input  logic [SAW:0]   map_wdata,
    input  logic [VAW-1:0] map_raddr,
    output logic [SAW:0]   map_rdata
);
    logic [VAW-1:0] list_mem [LIST_DEPTH];
    logic [SAW:0]   map_mem  [MAP_DEPTH];

    always_ff @(posedge aclk) begin
        if (list_we) begin
            list_mem[list_waddr] <= list_wdata;
        end
        list_rdata <= list_mem[list_raddr];
    end

    // top bit of a map word marks the vertex as selected
    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_waddr] <= map_wdata;
        end
        map_rdata <= map_mem[map_raddr];
    end

endmodule

[rtl/induced_subgraph_extractor_top.sv]
// induced subgraph extractor: sequencer, output register and graph/set memories
// load, append, error beats: result waits for a free output register, then back to idle
// extract: list read, pointer read, per row edge an edge read then a map read, row end
// new set: map clearing pass over all MAX_VERTICES map entries before its acknowledge
// after aresetn (synchronous, active low) the same clearing pass runs, no beat accepted
// graph stores and selected list are not cleared; reading them before a write is undefined
module induced_subgraph_extractor_top #(
    parameter int MAX_VERTICES = ise_pkg::DEF_MAX_VERTICES,
    parameter int MAX_EDGES    = ise_pkg::DEF_MAX_EDGES,
    parameter int MAX_DEGREE   = ise_pkg::DEF_MAX_DEGREE,
    parameter int MAX_SELECTED = ise_pkg::DEF_MAX_SELECTED
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [ise_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [ise_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // mode, slot, vertex, pointer_value, edge_id
    input  logic [ise_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // new_column, orig_edge_id, running_total, status, zero pad
    output logic [ise_pkg::M_TDATA_W-1:0]  m_tdata,
    // kind
    output logic [ise_pkg::KIND_W-1:0]     m_tuser,
    output logic                           m_tlast
);
    import ise_pkg::*;

    localparam int VAW   = $clog2(MAX_VERTICES);
    localparam int RAW   = $clog2(MAX_VERTICES + 1);
    localparam int EAW   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int SAW   = (MAX_SELECTED > 1) ? $clog2(MAX_SELECTED) : 1;
    localparam int CNTW  = $clog2(MAX_SELECTED + 1);
    localparam int PREVW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_EMIT, ST_X_LIST, ST_X_PTR,
        ST_E_ISSUE, ST_E_DATA, ST_M_DATA, ST_ROWEND
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [GVC_W-1:0] gvc_reg;
    logic             emit_reg;

    // set bookkeeping
    logic [CNTW-1:0]    count_reg;
    logic [PREVW-1:0]   prev_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [VAW-1:0]     clr_addr_reg;
    logic               clr_ack_reg;

    // extract walk
    logic [SAW-1:0]   pos_reg;
    logic [EAW-1:0]   edge_addr_reg;
    logic [DEG_W-1:0] left_reg;

    // pending single result
    kind_t   res_kind_reg;
    status_t res_status_reg;

    // output register
    logic               m_valid_reg;
    kind_t              out_kind_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [EID_W-1:0]   out_eid_reg;
    logic [TOTAL_W-1:0] out_total_reg;
    status_t            out_status_reg;
    logic               out_last_reg;

    // input beat fields
    logic [MODE_W-1:0]   in_mode;
    logic [SLOT_W-1:0]   in_slot;
    logic [VERTEX_W-1:0] in_vertex;
    logic [PTR_W-1:0]    in_ptr;
    logic [EID_W-1:0]    in_eid;

    assign in_mode   = s_tdata[2:0];
    assign in_slot   = s_tdata[15:3];
    assign in_vertex = s_tdata[25:16];
    assign in_ptr    = s_tdata[39:26];
    assign in_eid    = s_tdata[71:40];

    // memory ports
    logic                rp_we, ed_we, list_we, map_we;
    logic [RAW-1:0]      rp_waddr, rp_raddr_a, rp_raddr_b;
    logic [PTR_W-1:0]    rp_rdata_a, rp_rdata_b;
    logic [EAW-1:0]      ed_waddr;
    logic [VERTEX_W-1:0] ed_rcol;
    logic [EID_W-1:0]    ed_rid;
    logic [SAW-1:0]      list_waddr, list_raddr;
    logic [VAW-1:0]      list_wdata, list_rdata;
    logic [VAW-1:0]      map_waddr, map_raddr;
    logic [SAW:0]        map_wdata, map_rdata;

    // working values, widened for range compares
    logic        accept, out_free, out_load, keep, col_ok, row_bad, clr_done;
    logic [31:0] slot_w, vtx_w, vtx_p1_w, lim_w, v_w, v_p1_w, start_w, len_w, col_w;
    logic [PTR_W-1:0]   row_len;
    logic [TOTAL_W-1:0] total_inc;
    status_t            app_status;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;
    // output register takes a new beat this cycle
    assign out_load = out_free && ((state_reg == ST_EMIT) || (state_reg == ST_ROWEND) ||
                                   ((state_reg == ST_M_DATA) && keep));

    assign slot_w   = 32'(in_slot);
    assign vtx_w    = 32'(in_vertex);
    assign vtx_p1_w = vtx_w + 32'd1;
    // vertex count above the store size acts as the store size
    assign lim_w    = (32'(gvc_reg) > MAX_VERTICES) ? MAX_VERTICES : 32'(gvc_reg);

    // append checks in priority order
    always_comb begin
        priority if (vtx_w >= lim_w) begin
            app_status = STAT_VERT_RANGE;
        end else if (vtx_p1_w < 32'(prev_reg)) begin
            app_status = STAT_UNSORTED;
        end else if (32'(count_reg) >= MAX_SELECTED) begin
            app_status = STAT_LIST_FULL;
        end else begin
            app_status = STAT_OK;
        end
    end

    // graph loads write straight from the accepted beat
    assign rp_we    = accept && (in_mode == MODE_LOAD_PTR) && !(slot_w > MAX_VERTICES);
    assign rp_waddr = slot_w[RAW-1:0];
    assign ed_we    = accept && (in_mode == MODE_LOAD_EDGE) && (slot_w < MAX_EDGES);
    assign ed_waddr = slot_w[EAW-1:0];

    // list entry and map entry written together on a good append
    assign list_we    = accept && (in_mode == MODE_APPEND) && (app_status == STAT_OK);
    assign list_waddr = count_reg[SAW-1:0];
    assign list_wdata = vtx_w[VAW-1:0];
    assign list_raddr = (state_reg == ST_IDLE) ? slot_w[SAW-1:0] : pos_reg;

    // row pointers of the listed vertex and its successor
    assign v_w        = 32'(list_rdata);
    assign v_p1_w     = v_w + 32'd1;
    assign rp_raddr_a = v_w[RAW-1:0];
    assign rp_raddr_b = v_p1_w[RAW-1:0];
    assign row_len    = rp_rdata_b - rp_rdata_a;
    assign start_w    = 32'(rp_rdata_a);
    assign len_w      = 32'(row_len);
    assign row_bad    = (len_w > MAX_DEGREE) || (start_w + len_w > MAX_EDGES);

    // map lookup of the edge column; clearing pass owns the write port
    assign col_w     = 32'(ed_rcol);
    assign col_ok    = col_w < MAX_VERTICES;
    assign map_raddr = col_w[VAW-1:0];
    assign keep      = col_ok && map_rdata[SAW];
    assign map_we    = (state_reg == ST_CLEAR) || list_we;
    assign map_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg : vtx_w[VAW-1:0];
    assign map_wdata = (state_reg == ST_CLEAR) ? '0 : {1'b1, count_reg[SAW-1:0]};
    assign clr_done  = (clr_addr_reg == VAW'(MAX_VERTICES - 1));

    assign total_inc = (total_reg == TOTAL_MAX) ? total_reg : total_reg + 1'b1;

    ise_graph_mem #(
        .RAW(RAW), .EAW(EAW), .RP_DEPTH(MAX_VERTICES + 1), .ED_DEPTH(MAX_EDGES)
    ) u_graph (
        .aclk(aclk),
        .rp_we(rp_we), .rp_waddr(rp_waddr), .rp_wdata(in_ptr),
        .rp_raddr_a(rp_raddr_a), .rp_raddr_b(rp_raddr_b),
        .rp_rdata_a(rp_rdata_a), .rp_rdata_b(rp_rdata_b),
        .ed_we(ed_we), .ed_waddr(ed_waddr), .ed_wcol(in_vertex), .ed_wid(in_eid),
        .ed_raddr(edge_addr_reg), .ed_rcol(ed_rcol), .ed_rid(ed_rid)
    );

    ise_set_mem #(
        .VAW(VAW), .SAW(SAW), .LIST_DEPTH(MAX_SELECTED), .MAP_DEPTH(MAX_VERTICES)
    ) u_set (
        .aclk(aclk),
        .list_we(list_we), .list_waddr(list_waddr), .list_wdata(list_wdata),
        .list_raddr(list_raddr), .list_rdata(list_rdata),
        .map_we(map_we), .map_waddr(map_waddr), .map_wdata(map_wdata),
        .map_raddr(map_raddr), .map_rdata(map_rdata)
    );

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gvc_reg  <= GVC_RESET;
            emit_reg <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                CFG_VERTEX_COUNT: gvc_reg  <= cfg_wdata[GVC_W-1:0];
                CFG_EMIT_IDS:     emit_reg <= cfg_wdata[0];
            endcase
        end
    end

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            clr_ack_reg  <= 1'b0;
            count_reg    <= '0;
            prev_reg     <= '0;
            total_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready && !out_load) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_done) begin
                        res_kind_reg   <= KIND_ACK;
                        res_status_reg <= STAT_OK;
                        state_reg      <= clr_ack_reg ? ST_EMIT : ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        res_kind_reg   <= KIND_ACK;
                        res_status_reg <= STAT_OK;
                        state_reg      <= ST_EMIT;
                        unique case (in_mode)
                            MODE_LOAD_PTR: begin
                                if (slot_w > MAX_VERTICES) begin
                                    res_kind_reg   <= KIND_ERROR;
                                    res_status_reg <= STAT_BAD_POS;
                                end
                            end
                            MODE_LOAD_EDGE: begin
                                if (slot_w >= MAX_EDGES) begin
                                    res_kind_reg   <= KIND_ERROR;
                                    res_status_reg <= STAT_BAD_POS;
                                end
                            end
                            MODE_APPEND: begin
                                if (app_status != STAT_OK) begin
                                    res_kind_reg   <= KIND_ERROR;
                                    res_status_reg <= app_status;
                                end else begin
                                    count_reg <= count_reg + 1'b1;
                                    prev_reg  <= vtx_p1_w[PREVW-1:0];
                                end
                            end
                            MODE_EXTRACT: begin
                                if (slot_w >= 32'(count_reg) || slot_w >= MAX_SELECTED) begin
                                    res_kind_reg   <= KIND_ERROR;
                                    res_status_reg <= STAT_BAD_POS;
                                end else begin
                                    pos_reg   <= slot_w[SAW-1:0];
                                    state_reg <= ST_X_LIST;
                                end
                            end
                            MODE_NEW_SET: begin
                                count_reg    <= '0;
                                prev_reg     <= '0;
                                total_reg    <= '0;
                                clr_addr_reg <= '0;
                                clr_ack_reg  <= 1'b1;
                                state_reg    <= ST_CLEAR;
                            end
                            default: begin
                                res_kind_reg   <= KIND_ERROR;
                                res_status_reg <= STAT_BAD_POS;
                            end
                        endcase
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        out_kind_reg   <= res_kind_reg;
                        out_col_reg    <= '0;
                        out_eid_reg    <= '0;
                        out_total_reg  <= total_reg;
                        out_status_reg <= res_status_reg;
                        out_last_reg   <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                ST_X_LIST: begin
                    if (v_w >= lim_w) begin
                        res_kind_reg   <= KIND_ERROR;
                        res_status_reg <= STAT_VERT_RANGE;
                        state_reg      <= ST_EMIT;
                    end else begin
                        state_reg <= ST_X_PTR;
                    end
                end
                ST_X_PTR: begin
                    if (row_bad) begin
                        res_kind_reg   <= KIND_ERROR;
                        res_status_reg <= STAT_ROW_LONG;
                        state_reg      <= ST_EMIT;
                    end else begin
                        edge_addr_reg <= start_w[EAW-1:0];
                        left_reg      <= row_len[DEG_W-1:0];
                        state_reg     <= (row_len == '0) ? ST_ROWEND : ST_E_ISSUE;
                    end
                end
                ST_E_ISSUE: begin
                    state_reg <= ST_E_DATA;
                end
                ST_E_DATA: begin
                    state_reg <= ST_M_DATA;
                end
                ST_M_DATA: begin
                    // a kept edge waits for the output register, a dropped one moves on
                    if (!keep || out_free) begin
                        if (keep) begin
                            m_valid_reg    <= 1'b1;
                            out_kind_reg   <= KIND_EDGE;
                            out_col_reg    <= COL_W'(map_rdata[SAW-1:0]);
                            out_eid_reg    <= emit_reg ? ed_rid : '0;
                            out_total_reg  <= total_inc;
                            out_status_reg <= STAT_OK;
                            out_last_reg   <= 1'b0;
                            total_reg      <= total_inc;
                        end
                        edge_addr_reg <= edge_addr_reg + 1'b1;
                        left_reg      <= left_reg - 1'b1;
                        state_reg     <= (left_reg == DEG_W'(1)) ? ST_ROWEND : ST_E_ISSUE;
                    end
                end
                ST_ROWEND: begin
                    if (out_free) begin
                        m_valid_reg    <= 1'b1;
                        out_kind_reg   <= KIND_ROW_END;
                        out_col_reg    <= '0;
                        out_eid_reg    <= '0;
                        out_total_reg  <= total_reg;
                        out_status_reg <= STAT_OK;
                        out_last_reg   <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {5'd0, out_status_reg, out_total_reg, out_eid_reg, out_col_reg};

`ifndef NO_ASSERTIONS
    // one beat in flight: nothing accepted right after a beat is taken
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("input beat accepted while another is in progress");

    // kept edges are never the closing beat and never carry an error
    a_edge_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_kind_reg == KIND_EDGE) |-> (!out_last_reg && out_status_reg == STAT_OK))
        else $error("kept edge flagged last or with nonzero status");

    // row walk never exceeds the degree limit
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_E_ISSUE || state_reg == ST_E_DATA || state_reg == ST_M_DATA)
        |-> (left_reg != '0 && 32'(left_reg) <= MAX_DEGREE))
        else $error("row walk count out of range");
`endif

endmodule
